>>> src/tcve_pkg.sv
`timescale 1ns / 1ps

package tcve_pkg;

   // packet limits
   localparam int MAX_PACKET_BYTES_DEF = 256;
   localparam int HDR_DEPTH            = 13;
   localparam int ECHO_LEN             = 40;
   localparam int ECHO_SUM_BYTES       = 34;
   localparam int QUEUE_DEPTH          = 2;

   // opcodes
   localparam logic [10:0] OP_NOOP     = 11'h000;
   localparam logic [10:0] OP_SET_TIME = 11'h006;
   localparam logic [10:0] OP_HK_RATE  = 11'h039;
   localparam logic [10:0] OP_SCI_RATE = 11'h048;
   localparam logic [10:0] OP_POWER    = 11'h096;

   // echo packet constants
   localparam logic [7:0] ECHO_ID0    = 8'h08;
   localparam logic [7:0] ECHO_ID1    = 8'h75;
   localparam logic [7:0] ECHO_LENGTH = 8'(36 - 7);
   localparam logic [7:0] ECHO_TYPE   = 8'h0E;
   localparam logic [7:0] SYNC0       = 8'h1A;
   localparam logic [7:0] SYNC1       = 8'hCF;
   localparam logic [7:0] SYNC2       = 8'hFC;
   localparam logic [7:0] SYNC3       = 8'h1D;
   localparam logic [7:0] OPCODE_HI_MASK = 8'b0000_0111;

   // reset values of the rate registers
   localparam logic [15:0] HK_RATE_RESET  = 16'd3;
   localparam logic [15:0] SCI_RATE_RESET = 16'd10;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_LENGTH  = 3'd1,
      STATUS_BAD_OPCODE  = 3'd2,
      STATUS_BAD_SUM     = 3'd3,
      STATUS_BAD_ARG     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      POWER_NONE     = 3'd0,
      POWER_HARD_OFF = 3'd1,
      POWER_HARD_ON  = 3'd2,
      POWER_SOFT_OFF = 3'd3,
      POWER_SOFT_ON  = 3'd4
   } power_type;

   // everything the echo generator needs for one command
   typedef struct packed {
      logic [15:0] seq;
      logic [31:0] sec;
      logic [19:0] usec;
      logic [7:0]  opcode_low;
      status_type  status;
      logic [15:0] accept_count;
      logic [15:0] reject_count;
      logic [15:0] hk_rate;
      logic [15:0] sci_rate;
      power_type   action;
      logic        load;
      logic [31:0] load_sec;
      logic [19:0] load_usec;
   } job_type;

endpackage

>>> src/tcve_if.sv
`timescale 1ns / 1ps

// command byte channel
interface tcve_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  cmd_byte;
   logic        last_byte;
   logic [31:0] now_sec;
   logic [19:0] now_usec;

   modport source (output valid, cmd_byte, last_byte, now_sec, now_usec, input ready);
   modport sink (input valid, cmd_byte, last_byte, now_sec, now_usec, output ready);
endinterface

// echo byte channel
interface tcve_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  echo_byte;
   logic        echo_last;
   logic [2:0]  cmd_status;
   logic [2:0]  power_action;
   logic        time_load;
   logic [31:0] load_sec;
   logic [19:0] load_usec;
   logic [15:0] hk_rate;
   logic [15:0] sci_rate;

   modport source (output valid, echo_byte, echo_last, cmd_status, power_action, time_load,
                   load_sec, load_usec, hk_rate, sci_rate, input ready);
   modport sink (input valid, echo_byte, echo_last, cmd_status, power_action, time_load,
                 load_sec, load_usec, hk_rate, sci_rate, output ready);
endinterface

>>> src/tcve_front.sv
`timescale 1ns / 1ps

module tcve_front #(
   parameter int MAX_PACKET_BYTES = tcve_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   tcve_req_if.sink          req,
   input  logic              q_full,
   output logic              push,
   output tcve_pkg::job_type job
);
   import tcve_pkg::*;

   localparam int CountWidth = $clog2(MAX_PACKET_BYTES + 1);

   logic [7:0]            header_ff [HDR_DEPTH];
   logic [CountWidth-1:0] count_ff, count_in;
   logic [15:0]           sum_ff, sum_in;
   logic [7:0]            prior_ff [2];
   logic [7:0]            prior_in [2];
   logic [15:0]           accept_ff, accept_in;
   logic [15:0]           reject_ff, reject_in;
   logic [15:0]           seq_ff, seq_in;
   logic [15:0]           hk_ff, hk_in;
   logic [15:0]           sci_ff, sci_in;

   logic        accept;
   logic [7:0]  pkt [HDR_DEPTH];
   logic [15:0] total;
   logic [15:0] trailer;
   logic [10:0] opcode;
   logic        sum_ok;
   status_type  status;
   power_type   action;
   logic        load;
   logic [31:0] lsec;
   logic [19:0] lusec;
   logic [15:0] rate;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && req.last_byte;

   // packet view: bytes past the current one read as zero, current byte bypassed
   always_comb begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
         if (count_ff > CountWidth'(i)) begin
            pkt[i] = header_ff[i];
         end else if (count_ff == CountWidth'(i)) begin
            pkt[i] = req.cmd_byte;
         end else begin
            pkt[i] = 8'h00;
         end
      end
   end

   // trailer check and command decode
   always_comb begin
      total   = sum_ff + {8'h00, prior_ff[0]};
      trailer = {req.cmd_byte, prior_ff[1]};
      opcode  = {pkt[0][2:0] & OPCODE_HI_MASK[2:0], pkt[1]};
      sum_ok  = (count_ff >= CountWidth'(7)) &&
                (count_ff < CountWidth'(MAX_PACKET_BYTES)) && (total == trailer);
      rate    = {pkt[7], pkt[6]};
      status  = STATUS_OK;
      action  = POWER_NONE;
      load    = 1'b0;
      lsec    = '0;
      lusec   = '0;
      if (!sum_ok) begin
         status = STATUS_BAD_SUM;
      end else begin
         unique case (opcode)
            OP_NOOP: begin
               status = STATUS_OK;
            end
            OP_SET_TIME: begin
               load  = 1'b1;
               lsec  = {pkt[9], pkt[8], pkt[7], pkt[6]};
               lusec = {pkt[12][3:0], pkt[11], pkt[10]};
            end
            OP_HK_RATE, OP_SCI_RATE: begin
               if (count_ff != CountWidth'(9)) begin
                  status = STATUS_BAD_LENGTH;
               end
            end
            OP_POWER: begin
               if (count_ff != CountWidth'(8)) begin
                  status = STATUS_BAD_LENGTH;
               end else begin
                  unique case (pkt[6])
                     8'h00:   action = POWER_HARD_OFF;
                     8'h01:   action = POWER_HARD_ON;
                     8'h10:   action = POWER_SOFT_OFF;
                     8'h11:   action = POWER_SOFT_ON;
                     default: status = STATUS_BAD_ARG;
                  endcase
               end
            end
            default: begin
               status = STATUS_BAD_OPCODE;
            end
         endcase
      end
   end

   // next state of the command counters and rate registers
   always_comb begin
      accept_in = accept_ff;
      reject_in = reject_ff;
      hk_in     = hk_ff;
      sci_in    = sci_ff;
      seq_in    = seq_ff;
      if (push) begin
         seq_in = seq_ff + 16'd1;
         if (sum_ok) begin
            if (status == STATUS_OK) begin
               accept_in = accept_ff + 16'd1;
               if (opcode == OP_HK_RATE) begin
                  hk_in = rate;
               end
               if (opcode == OP_SCI_RATE) begin
                  sci_in = rate;
               end
            end else begin
               reject_in = reject_ff + 16'd1;
            end
         end
      end
   end

   // next state of the packet accumulator
   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      prior_in[0] = prior_ff[0];
      prior_in[1] = prior_ff[1];
      if (accept) begin
         if (req.last_byte) begin
            count_in    = '0;
            sum_in      = '0;
            prior_in[0] = 8'h00;
            prior_in[1] = 8'h00;
         end else begin
            sum_in      = total;
            prior_in[0] = prior_ff[1];
            prior_in[1] = req.cmd_byte;
            if (count_ff < CountWidth'(MAX_PACKET_BYTES)) begin
               count_in = count_ff + CountWidth'(1);
            end
         end
      end
   end

   // job for the echo generator
   always_comb begin
      job.seq          = seq_ff;
      job.sec          = load ? lsec : req.now_sec;
      job.usec         = load ? lusec : req.now_usec;
      job.opcode_low   = opcode[7:0];
      job.status       = status;
      job.accept_count = accept_in;
      job.reject_count = reject_in;
      job.hk_rate      = hk_in;
      job.sci_rate     = sci_in;
      job.action       = action;
      job.load         = load;
      job.load_sec     = lsec;
      job.load_usec    = lusec;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         prior_ff[0] <= 8'h00;
         prior_ff[1] <= 8'h00;
         accept_ff   <= '0;
         reject_ff   <= '0;
         seq_ff      <= '0;
         hk_ff       <= HK_RATE_RESET;
         sci_ff      <= SCI_RATE_RESET;
      end else begin
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         prior_ff[0] <= prior_in[0];
         prior_ff[1] <= prior_in[1];
         accept_ff   <= accept_in;
         reject_ff   <= reject_in;
         seq_ff      <= seq_in;
         hk_ff       <= hk_in;
         sci_ff      <= sci_in;
      end
   end

   // header capture
   always_ff @(posedge clock) begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
         if (accept && count_ff == CountWidth'(i)) begin
            header_ff[i] <= req.cmd_byte;
         end
      end
   end

endmodule

>>> src/tcve_queue.sv
`timescale 1ns / 1ps

module tcve_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcve_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output tcve_pkg::job_type head_job
);
   import tcve_pkg::*;

   localparam int PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   job_type               entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ff, wr_in;
   logic [PtrWidth-1:0]   rd_ff, rd_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full       = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ff];

   // pointer and occupancy update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> src/tcve_echo.sv
`timescale 1ns / 1ps

module tcve_echo (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  tcve_pkg::job_type head_job,
   output logic              pop,
   tcve_rsp_if.source        rsp
);
   import tcve_pkg::*;

   localparam int IdxWidth = $clog2(ECHO_LEN);

   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic [15:0]         csum_ff, csum_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff;
   logic                last_ff;
   logic [2:0]          status_ff;
   logic [2:0]          action_ff;
   logic                load_ff;
   logic [31:0]         lsec_ff;
   logic [19:0]         lusec_ff;
   logic [15:0]         hk_ff;
   logic [15:0]         sci_ff;

   logic       advance;
   logic       emit;
   logic       first;
   logic       last;
   logic [7:0] echo [ECHO_LEN];
   logic [7:0] cur_byte;

   assign advance = !valid_ff || rsp.ready;
   assign emit    = advance && head_valid;
   assign first   = (idx_ff == '0);
   assign last    = (idx_ff == IdxWidth'(ECHO_LEN - 1));
   assign pop     = emit && last;

   // echo packet layout
   always_comb begin
      for (int i = 0; i < ECHO_LEN; i++) begin
         echo[i] = 8'h00;
      end
      echo[0]  = ECHO_ID0;
      echo[1]  = ECHO_ID1;
      echo[2]  = head_job.seq[15:8];
      echo[3]  = head_job.seq[7:0];
      echo[5]  = ECHO_LENGTH;
      echo[6]  = ECHO_TYPE;
      echo[9]  = {head_job.usec[3:0], 4'h0};
      echo[10] = head_job.usec[11:4];
      echo[11] = head_job.usec[19:12];
      echo[12] = head_job.sec[7:0];
      echo[13] = head_job.sec[15:8];
      echo[14] = head_job.sec[23:16];
      echo[15] = head_job.sec[31:24];
      echo[17] = head_job.opcode_low;
      echo[18] = {5'h00, head_job.status};
      echo[19] = head_job.accept_count[7:0];
      echo[20] = head_job.accept_count[15:8];
      echo[21] = head_job.reject_count[7:0];
      echo[22] = head_job.reject_count[15:8];
      echo[34] = csum_ff[7:0];
      echo[35] = csum_ff[15:8];
      echo[36] = SYNC0;
      echo[37] = SYNC1;
      echo[38] = SYNC2;
      echo[39] = SYNC3;
      cur_byte = echo[idx_ff];
   end

   // byte index, running echo sum and output valid
   always_comb begin
      idx_in   = idx_ff;
      csum_in  = csum_ff;
      valid_in = valid_ff;
      if (rsp.ready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
         idx_in   = last ? '0 : idx_ff + IdxWidth'(1);
         if (first) begin
            csum_in = {8'h00, cur_byte};
         end else if (idx_ff < IdxWidth'(ECHO_SUM_BYTES)) begin
            csum_in = csum_ff + {8'h00, cur_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      csum_ff <= csum_in;
      if (emit) begin
         byte_ff   <= cur_byte;
         last_ff   <= last;
         status_ff <= head_job.status;
         action_ff <= first ? head_job.action : POWER_NONE;
         load_ff   <= first && head_job.load;
         lsec_ff   <= first ? head_job.load_sec : 32'h0;
         lusec_ff  <= first ? head_job.load_usec : 20'h0;
         hk_ff     <= head_job.hk_rate;
         sci_ff    <= head_job.sci_rate;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.echo_byte    = byte_ff;
   assign rsp.echo_last    = last_ff;
   assign rsp.cmd_status   = status_ff;
   assign rsp.power_action = action_ff;
   assign rsp.time_load    = load_ff;
   assign rsp.load_sec     = lsec_ff;
   assign rsp.load_usec    = lusec_ff;
   assign rsp.hk_rate      = hk_ff;
   assign rsp.sci_rate     = sci_ff;

endmodule

>>> src/telecommand_validate_and_echo.sv
`timescale 1ns / 1ps
// Throughput: one command byte per cycle while the queue is not full; each packet then yields
// 40 echo bytes at one per cycle while the receiver is ready, paced by the echo byte counter.
// A two-entry command queue lets the next packet stream in while an echo is being sent; input
// stalls only when both entries are waiting.
// Reset (synchronous, active high) clears counters, queue and output valid; rates go to 3, 10.
module telecommand_validate_and_echo #(
   parameter int MAX_PACKET_BYTES = tcve_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tcve_req_if.sink   req_chan,
   tcve_rsp_if.source rsp_chan
);
   import tcve_pkg::*;

   logic    push;
   logic    pop;
   logic    q_full;
   logic    head_valid;
   job_type push_job;
   job_type head_job;

   // command parsing and execution
   tcve_front #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .push   (push),
      .job    (push_job)
   );

   // decoupling queue
   tcve_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // echo packet generation
   tcve_echo u_echo (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule
